@@ design/bsrm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsrm_pkg
// Shared types and constants for the one-bit stream resampler.
// ----------------------------------------------------------------------------
package bsrm_pkg;

  localparam int STEP_W        = 24;
  localparam int RUN_W         = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_OUT_DEF   = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic ge;
    logic zero;
    logic half_ok;
  } unit_flags_t;

endpackage

@@ design/bsrm_step_unit.sv @@
// ----------------------------------------------------------------------------
// bsrm_step_unit
// Shared subtract/compare and saturating position adder, reused by every
// scan and finish step of the sequencer.
// ----------------------------------------------------------------------------
module bsrm_step_unit #(
  parameter int DW = 25
) (
  input  logic [DW-1:0]                opa,
  input  logic [DW-1:0]                opb,
  input  logic [bsrm_pkg::RUN_W-1:0]   pos,
  input  logic [DW-1:0]                step,
  output logic [DW-1:0]                diff,
  output logic [bsrm_pkg::RUN_W-1:0]   pos_sum,
  output bsrm_pkg::unit_flags_t        flags
);

  localparam int RW = bsrm_pkg::RUN_W;

  logic [DW:0]   sub_full;
  logic [DW:0]   add_full;
  logic [DW+1:0] twice_off;

  assign sub_full = {1'b0, opa} - {1'b0, opb};
  assign diff     = sub_full[DW-1:0];

  assign add_full = {1'b0, opb} + (DW+1)'(pos);
  assign pos_sum  = (add_full[DW:RW] != '0) ? '1 : add_full[RW-1:0];

  assign twice_off = (DW+2)'({pos_sum, 1'b0});

  assign flags.ge      = !sub_full[DW];
  assign flags.zero    = (diff == '0);
  assign flags.half_ok = (twice_off >= (DW+2)'(step));

endmodule

@@ design/bit_stream_resampler_majority.sv @@
// ----------------------------------------------------------------------------
// bit_stream_resampler_majority
// Resamples a one-bit level stream from a source rate to a target rate.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one source sample level per word.
// Output channel out_valid/out_ready carries one resampled bit per word;
// last_of_item marks the final bit caused by a sample. A sample with no
// scan point in it produces no output word.
// cfg_we/cfg_wdata write step_ratio (UQ8.16 by default, source over target
// rate); write it only while the block is idle.
// Sequence: a sample yielding n bits occupies the block through accept,
// one shared-unit pass per bit, one closing pass and one finish step. Each
// bit passes the pending register, then the output register, one per cycle
// unless the receiver stalls; the single subtract/compare unit sets the pace.
// in_ready is high only between samples.
// When the receiver stalls, the held bit stays in the output register and
// the sequencer holds; the next sample may be taken while the last bit of
// the previous one still waits.
// Reset (rst, synchronous) restores step_ratio to equal rates, places the
// first scan point one step ahead, and starts with a low run.
// ----------------------------------------------------------------------------
module bit_stream_resampler_majority #(
  parameter int FRAC_BITS          = bsrm_pkg::FRAC_BITS_DEF,
  parameter int MAX_OUT_PER_SAMPLE = bsrm_pkg::MAX_OUT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bsrm_pkg::STEP_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        sample_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_bit,
  output logic                        last_of_item
);

  localparam int SW = bsrm_pkg::STEP_W;
  localparam int RW = bsrm_pkg::RUN_W;
  localparam int DW = (FRAC_BITS + 1 > SW) ? FRAC_BITS + 1 : SW;
  localparam int NW = $clog2(MAX_OUT_PER_SAMPLE + 1);
  localparam int MIN_STEP_INT =
    ((1 << FRAC_BITS) + MAX_OUT_PER_SAMPLE - 1) / MAX_OUT_PER_SAMPLE;

  localparam logic [DW-1:0] ONE_UNIT   = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] MIN_STEP   = DW'(MIN_STEP_INT);
  localparam logic [DW-1:0] SCAN_RESET =
    (DW'(bsrm_pkg::STEP_RESET) < MIN_STEP) ? MIN_STEP : DW'(bsrm_pkg::STEP_RESET);
  localparam logic [NW-1:0] MAX_N      = NW'(MAX_OUT_PER_SAMPLE);

  bsrm_pkg::state_t state, state_next;

  logic [SW-1:0] step_ratio;
  logic [DW-1:0] scan_distance;
  logic [RW-1:0] run_position;
  logic          run_level;
  logic          prior_run_level;
  logic          run_emitted;
  logic [DW-1:0] remaining;
  logic [RW-1:0] pos;
  logic [NW-1:0] count;
  logic          pend_bit;
  logic          pend_valid;

  logic [DW-1:0] eff_step;
  logic [DW-1:0] opa;
  logic [DW-1:0] opb;
  logic [DW-1:0] diff;
  logic [RW-1:0] pos_sum;
  bsrm_pkg::unit_flags_t flags;

  logic accept;
  logic hit;
  logic stall;
  logic push;
  logic push_last;
  logic advance;
  logic finish;
  logic new_bit;

  assign eff_step = (DW'(step_ratio) < MIN_STEP) ? MIN_STEP : DW'(step_ratio);
  assign opa      = (state == bsrm_pkg::ST_FINISH) ? scan_distance : remaining;
  assign opb      = (state == bsrm_pkg::ST_FINISH) ? remaining : scan_distance;

  bsrm_step_unit #(
    .DW(DW)
  ) u_unit (
    .opa     (opa),
    .opb     (opb),
    .pos     (pos),
    .step    (eff_step),
    .diff    (diff),
    .pos_sum (pos_sum),
    .flags   (flags)
  );

  assign hit     = flags.ge && (count < MAX_N);
  assign stall   = pend_valid && out_valid && !out_ready;
  assign new_bit = (!run_emitted && (prior_run_level != run_level)) ?
                   (flags.half_ok ? run_level : prior_run_level) : run_level;

  always_comb begin
    state_next = state;
    unique case (state)
      bsrm_pkg::ST_IDLE: begin
        if (in_valid) state_next = bsrm_pkg::ST_SCAN;
      end
      bsrm_pkg::ST_SCAN: begin
        if (!stall && !hit) state_next = bsrm_pkg::ST_FINISH;
      end
      bsrm_pkg::ST_FINISH: begin
        state_next = bsrm_pkg::ST_IDLE;
      end
      default: begin
        state_next = bsrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == bsrm_pkg::ST_IDLE);
    accept    = in_valid && in_ready;
    push      = (state == bsrm_pkg::ST_SCAN) && pend_valid && !stall;
    push_last = !hit;
    advance   = (state == bsrm_pkg::ST_SCAN) && !stall && hit;
    finish    = (state == bsrm_pkg::ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsrm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio      <= bsrm_pkg::STEP_RESET;
      scan_distance   <= SCAN_RESET;
      run_position    <= '0;
      run_level       <= 1'b0;
      prior_run_level <= 1'b0;
      run_emitted     <= 1'b0;
      count           <= '0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_ratio <= cfg_wdata;
      end
      if (accept) begin
        if (sample_level != run_level) begin
          prior_run_level <= run_level;
          run_level       <= sample_level;
          run_emitted     <= 1'b0;
          pos             <= '0;
        end else begin
          pos <= run_position;
        end
        remaining  <= ONE_UNIT;
        count      <= '0;
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_bit      <= pend_bit;
        last_of_item <= push_last;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (push && !advance) begin
        pend_valid <= 1'b0;
      end
      if (advance) begin
        pend_bit      <= new_bit;
        pend_valid    <= 1'b1;
        run_emitted   <= 1'b1;
        remaining     <= diff;
        pos           <= pos_sum;
        scan_distance <= eff_step;
        count         <= count + NW'(1);
      end
      if (finish) begin
        scan_distance <= (flags.ge && !flags.zero) ? diff : eff_step;
        run_position  <= pos_sum;
      end
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("output word overwritten while held");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_N)
    else $error("more bits than allowed for one sample");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("pending bit left behind at sample boundary");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new sample taken while previous one in progress");

endmodule
